[hw/rtl/emrt_pkg.sv]
package emrt_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int IP_W    = 32;
    localparam int IFC_W   = 32;

    typedef enum logic
    {
        OP_SAVE = 1'b0,
        OP_FIND = 1'b1
    } opcode_t;

    typedef enum logic
    {
        ST_OK   = 1'b0,
        ST_FAIL = 1'b1
    } status_t;

    typedef struct packed
    {
        opcode_t           opcode;
        logic [IP_W-1:0]   dest_ip;
        logic [IFC_W-1:0]  interface_id;
    } req_item_t;

    typedef struct packed
    {
        status_t           status;
        logic [IFC_W-1:0]  found_interface;
    } rsp_item_t;

endpackage

[hw/rtl/exact_match_route_table_unit.sv]
// channel | valid     | stall     | payload
// request | req_valid | req_stall | req (req_item_t): opcode, dest_ip, interface_id
// reply   | rsp_valid | rsp_stall | rsp (rsp_item_t): status, found_interface
//
// one item at a time: a scan reads one stored key per cycle from the key ram,
// and a find hit adds one interface read; a zero address skips the scan.
// reset (rst_n low, async) empties the table by clearing the fill count only.
// a waiting reply does not block the next request; a new reply waits in its
// own state until the output register is free.
module exact_match_route_table_unit
    import emrt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_REPLY
    } state_t;

    state_t             state_reg, state_next;
    req_item_t          item_reg, item_next;
    rsp_item_t          res_reg, res_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic               check_reg, check_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_item_t          rsp_reg, rsp_next;

    logic               key_we;
    logic               key_re;
    logic [IP_W-1:0]    key_rdata;
    logic               ifc_we;
    logic [IDX_W-1:0]   ifc_waddr;
    logic               ifc_re;
    logic [IFC_W-1:0]   ifc_rdata;

    logic               hit;
    logic               full;
    logic               out_free;

    emrt_ram
    #(
        .WIDTH (IP_W),
        .DEPTH (ENTRIES)
    )
    u_key_ram
    (
        .clk   (clk),
        .we    (key_we),
        .waddr (used_reg[IDX_W-1:0]),
        .wdata (item_reg.dest_ip),
        .re    (key_re),
        .raddr (scan_reg[IDX_W-1:0]),
        .rdata (key_rdata)
    );

    emrt_ram
    #(
        .WIDTH (IFC_W),
        .DEPTH (ENTRIES)
    )
    u_ifc_ram
    (
        .clk   (clk),
        .we    (ifc_we),
        .waddr (ifc_waddr),
        .wdata (item_reg.interface_id),
        .re    (ifc_re),
        .raddr (chk_idx_reg),
        .rdata (ifc_rdata)
    );

    assign hit      = check_reg && (key_rdata == item_reg.dest_ip);
    assign full     = (used_reg == CNT_W'(ENTRIES));
    assign out_free = !rsp_valid_reg || !rsp_stall;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        used_next      = used_reg;
        scan_next      = scan_reg;
        check_next     = 1'b0;
        chk_idx_next   = chk_idx_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        key_we         = 1'b0;
        key_re         = 1'b0;
        ifc_we         = 1'b0;
        ifc_waddr      = chk_idx_reg;
        ifc_re         = 1'b0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next = req;
                    scan_next = '0;
                    if (req.dest_ip == '0)
                    begin
                        res_next.status          = ST_FAIL;
                        res_next.found_interface = '0;
                        state_next               = S_REPLY;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    if (item_reg.opcode == OP_SAVE)
                    begin
                        ifc_we                   = 1'b1;
                        res_next.status          = ST_OK;
                        res_next.found_interface = '0;
                        state_next               = S_REPLY;
                    end
                    else
                    begin
                        ifc_re     = 1'b1;
                        state_next = S_FETCH;
                    end
                end
                else if (scan_reg < used_reg)
                begin
                    // one key read per cycle, compared on the next
                    key_re       = 1'b1;
                    check_next   = 1'b1;
                    chk_idx_next = scan_reg[IDX_W-1:0];
                    scan_next    = scan_reg + 1'b1;
                end
                else
                begin
                    // no match among the used entries
                    res_next.found_interface = '0;
                    if (item_reg.opcode == OP_SAVE && !full)
                    begin
                        key_we          = 1'b1;
                        ifc_we          = 1'b1;
                        ifc_waddr       = used_reg[IDX_W-1:0];
                        used_next       = used_reg + 1'b1;
                        res_next.status = ST_OK;
                    end
                    else
                    begin
                        res_next.status = ST_FAIL;
                    end
                    state_next = S_REPLY;
                end
            end

            S_FETCH:
            begin
                res_next.status          = ST_OK;
                res_next.found_interface = ifc_rdata;
                state_next               = S_REPLY;
            end

            S_REPLY:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            res_reg       <= '0;
            used_reg      <= '0;
            scan_reg      <= '0;
            check_reg     <= 1'b0;
            chk_idx_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            res_reg       <= res_next;
            used_reg      <= used_next;
            scan_reg      <= scan_next;
            check_reg     <= check_next;
            chk_idx_reg   <= chk_idx_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

endmodule

[hw/rtl/emrt_ram.sv]
module emrt_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
